@@ src/descending_sorted_table_macros.svh @@
// Assertion macros shared by the sorted table RTL.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef DESCENDING_SORTED_TABLE_MACROS_SVH
`define DESCENDING_SORTED_TABLE_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define DST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define DST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dst_pkg.sv @@
// Shared types and constants for the descending sorted table.
// Used by dst_cell, descending_sorted_table and the testbench; depends on nothing.
package dst_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_FIELD_W = 5;
  localparam int unsigned IN_TDATA_W    = 32;
  localparam int unsigned OUT_TDATA_W   = 72;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  // Update strobes broadcast to every cell of the row
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

@@ src/dst_cell.sv @@
// One slot of the sorted row: holds a value, compares it with the request
// and shifts towards either neighbour. Depends on dst_pkg.
module dst_cell (
  input  logic                                   clk,
  input  logic                                   occ_i,
  input  logic                                   prev_stay_i,
  input  logic signed [dst_pkg::DATA_W-1:0]      prev_data_i,
  input  logic signed [dst_pkg::DATA_W-1:0]      next_data_i,
  input  logic signed [dst_pkg::DATA_W-1:0]      value_i,
  input  dst_pkg::cell_ctl_t                     ctl_i,
  output logic signed [dst_pkg::DATA_W-1:0]      data_o,
  output logic                                   stay_o,
  output logic                                   match_o
);

  logic signed [dst_pkg::DATA_W-1:0] data_r;
  logic signed [dst_pkg::DATA_W-1:0] data_nxt;
  logic                              gt;
  logic                              eq;
  logic                              shift_left;

  // Compare the stored value with the request
  assign gt         = data_r > value_i;
  assign eq         = data_r == value_i;
  assign stay_o     = occ_i & (gt | eq);
  assign match_o    = occ_i & eq;
  assign shift_left = occ_i & ~gt;
  assign data_o     = data_r;

  // Insert: keep, take the new value, or take the left neighbour.
  // Delete: cells at or past the first equal entry take the right neighbour.
  always_comb begin
    data_nxt = data_r;
    priority if (ctl_i.ins_en) begin
      if (!stay_o) begin
        data_nxt = prev_stay_i ? value_i : prev_data_i;
      end
    end else if (ctl_i.del_en && shift_left) begin
      data_nxt = next_data_i;
    end else begin
      data_nxt = data_r;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ src/descending_sorted_table.sv @@
// Descending sorted table of signed words, built as a row of dst_cell slots.
// Depends on dst_pkg, dst_cell and descending_sorted_table_macros.svh.
//
// Usage:
//   Requests arrive on the in_ stream: in_tuser is the kind (0 insert,
//   1 delete) and in_tdata the signed value. Each request yields exactly
//   one result on the out_ stream with status, entry count and the largest
//   and smallest stored values (zero when the table is empty).
//   The table updates at the input transfer; the request then stays pending
//   and the result is loaded into the output register from the updated
//   row, where the tail cell is selected for the smallest value. A new
//   request is not taken before the last result has been loaded.
//   in_tready stays low while a result waits to be loaded; a result already
//   held in the output register does not block the next request.
//   Stall: if out_tready is low, the held result stays put and the next
//   result waits inside, which in turn holds in_tready low.
//   Reset (rst_n low, synchronous) empties the table and drops any result;
//   cell contents are not cleared, as only occupied cells are ever read.
`include "descending_sorted_table_macros.svh"

module descending_sorted_table #(
  parameter int unsigned CAPACITY = dst_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dst_pkg::IN_TDATA_W-1:0]     in_tdata,  // [31:0] value
  input  logic                               in_tuser,  // [0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [6:2] entry_count, [38:7] largest, [70:39] smallest
  output logic [dst_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic                              pending_r;
  logic                              pending_nxt;
  dst_pkg::status_t                  stat_r;
  dst_pkg::status_t                  stat_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  dst_pkg::status_t                  out_status_r;
  logic [dst_pkg::COUNT_FIELD_W-1:0] out_count_r;
  logic signed [dst_pkg::DATA_W-1:0] out_largest_r;
  logic signed [dst_pkg::DATA_W-1:0] out_smallest_r;

  logic                              in_xfer;
  logic                              out_load;
  logic signed [dst_pkg::DATA_W-1:0] req_value;
  dst_pkg::kind_t                    req_kind;
  logic                              full;
  logic                              found;
  dst_pkg::cell_ctl_t                ctl;

  logic signed [dst_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]               cell_stay;
  logic [CAPACITY-1:0]               cell_match;
  logic [CAPACITY-1:0]               occ;
  logic [CAPACITY-1:0]               tail;
  logic signed [dst_pkg::DATA_W-1:0] small_sel;
  logic signed [dst_pkg::DATA_W-1:0] large_sel;

  // Unpack the request
  assign req_value = in_tdata[dst_pkg::DATA_W-1:0];
  assign req_kind  = dst_pkg::kind_t'(in_tuser);
  assign in_tready = ~pending_r;
  assign in_xfer   = in_tvalid & in_tready;

  // Table-wide conditions
  assign full  = count_r == CNT_W'(CAPACITY);
  assign found = |cell_match;

  assign ctl.ins_en = in_xfer & (req_kind == dst_pkg::KIND_INSERT) & ~full;
  assign ctl.del_en = in_xfer & (req_kind == dst_pkg::KIND_DELETE) & found;

  // Row of cells with neighbour links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              prev_stay;
    logic signed [dst_pkg::DATA_W-1:0] prev_data;
    logic signed [dst_pkg::DATA_W-1:0] next_data;

    assign occ[i] = count_r > CNT_W'(i);

    if (i == 0) begin : g_head
      assign prev_stay = 1'b1;
      assign prev_data = req_value;
    end else begin : g_body
      assign prev_stay = cell_stay[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[i];
      assign tail[i]   = occ[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
      assign tail[i]   = occ[i] & ~occ[i+1];
    end

    dst_cell u_cell (
      .clk         (clk),
      .occ_i       (occ[i]),
      .prev_stay_i (prev_stay),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .value_i     (req_value),
      .ctl_i       (ctl),
      .data_o      (cell_data[i]),
      .stay_o      (cell_stay[i]),
      .match_o     (cell_match[i])
    );
  end

  // Status and count for the accepted request
  always_comb begin
    stat_nxt  = stat_r;
    count_nxt = count_r;
    if (in_xfer) begin
      unique case (req_kind)
        dst_pkg::KIND_INSERT: begin
          stat_nxt = full ? dst_pkg::ST_FULL : dst_pkg::ST_DONE;
        end
        dst_pkg::KIND_DELETE: begin
          priority if (count_r == '0) begin
            stat_nxt = dst_pkg::ST_EMPTY;
          end else if (found) begin
            stat_nxt = dst_pkg::ST_DONE;
          end else begin
            stat_nxt = dst_pkg::ST_NOT_FOUND;
          end
        end
        default: stat_nxt = dst_pkg::ST_DONE;
      endcase
    end
    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Pick head and tail of the updated row
  always_comb begin
    small_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      small_sel = small_sel | (tail[i] ? cell_data[i] : '0);
    end
    large_sel = occ[0] ? cell_data[0] : '0;
  end

  // Load the result once the output register is free
  assign out_load = pending_r & (~out_valid_r | out_tready);

  always_comb begin
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      pending_nxt   = 1'b0;
    end
    if (in_xfer) begin
      pending_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    if (out_load) begin
      out_status_r   <= stat_r;
      out_count_r    <= dst_pkg::COUNT_FIELD_W'(count_r);
      out_largest_r  <= large_sel;
      out_smallest_r <= small_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_smallest_r, out_largest_r, out_count_r, out_status_r};

  `DST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `DST_ASSERT_NEXT(a_xfer_pending, in_xfer, pending_r, "accepted request not pending")
  `DST_ASSERT_NEXT(a_insert_count, ctl.ins_en, count_r == $past(count_r) + CNT_W'(1), "insert count")
  `DST_ASSERT_NOW(a_load_source, $rose(out_valid_r), $past(pending_r), "result without request")

endmodule

@@ verif/descending_sorted_table_checker.sv @@
`timescale 1ns / 1ps
// Checker for the descending sorted table: watches both stream channels,
// keeps its own copy of the table and compares every result transfer.
// Depends on dst_pkg for the status and kind codes and the channel widths.
module descending_sorted_table_checker #(
  parameter int unsigned CAPACITY = dst_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [dst_pkg::IN_TDATA_W-1:0]     in_tdata,  // [31:0] value
  input  logic                               in_tuser,  // [0] kind
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [6:2] entry_count, [38:7] largest, [70:39] smallest
  input  logic [dst_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output int                                 error_count,
  output int                                 pending_results,
  output int                                 full_rejects,
  output int                                 empty_rejects,
  output int                                 missing_deletes
);
  import dst_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [4:0]         count;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
  } table_result_t;

  // Shadow copy of the table, descending, first stored_n entries valid
  logic signed [31:0] entries [CAPACITY];
  int                 stored_n;
  table_result_t      expected_q [$];

  initial begin
    error_count     = 0;
    pending_results = 0;
    full_rejects    = 0;
    empty_rejects   = 0;
    missing_deletes = 0;
    stored_n        = 0;
  end

  // Apply one request to the shadow table and return the result it yields
  function automatic table_result_t apply_request(kind_t kind, logic signed [31:0] value);
    table_result_t res;
    int slot;
    res.status = ST_DONE;
    slot = 0;
    if (kind == KIND_INSERT) begin
      if (stored_n >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // Equal values stay ahead of the newcomer
        while (slot < stored_n && entries[slot] >= value) slot++;
        for (int i = stored_n; i > slot; i--) entries[i] = entries[i-1];
        entries[slot] = value;
        stored_n++;
      end
    end else begin
      if (stored_n == 0) begin
        res.status = ST_EMPTY;
      end else begin
        while (slot < stored_n && entries[slot] != value) slot++;
        if (slot >= stored_n) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = slot; i + 1 < stored_n; i++) entries[i] = entries[i+1];
          stored_n--;
        end
      end
    end
    res.count    = 5'(stored_n);
    res.largest  = (stored_n > 0) ? entries[0] : 32'sd0;
    res.smallest = (stored_n > 0) ? entries[stored_n-1] : 32'sd0;
    return res;
  endfunction

  task automatic note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Retire results before booking new requests: a result never stems from
  // a request accepted at the same edge
  always @(posedge clk) begin
    table_result_t want;
    table_result_t seen;
    if (!rst_n) begin
      expected_q.delete();
      stored_n = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.status   = status_t'(out_tdata[1:0]);
        seen.count    = out_tdata[6:2];
        seen.largest  = out_tdata[38:7];
        seen.smallest = out_tdata[70:39];
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result with none expected: status %0d count %0d",
                                 seen.status, seen.count));
        end else begin
          want = expected_q.pop_front();
          if (seen.status !== want.status || seen.count !== want.count ||
              seen.largest !== want.largest || seen.smallest !== want.smallest) begin
            note_failure($sformatf(
              "exp status %0d count %0d largest %0d smallest %0d, got %0d %0d %0d %0d",
              want.status, want.count, want.largest, want.smallest,
              seen.status, seen.count, seen.largest, seen.smallest));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_request(kind_t'(in_tuser), in_tdata[31:0]);
        case (want.status)
          ST_FULL:      full_rejects++;
          ST_EMPTY:     empty_rejects++;
          ST_NOT_FOUND: missing_deletes++;
          default: ;
        endcase
        expected_q.push_back(want);
      end
    end
    pending_results = expected_q.size();
  end

endmodule

@@ verif/descending_sorted_table_test.sv @@
`timescale 1ns / 1ps
// Top of the sorted table testbench: clock, reset, request stimulus and
// result back-pressure. Depends on dst_pkg, descending_sorted_table and
// descending_sorted_table_checker.
module descending_sorted_table_test;
  import dst_pkg::*;

  localparam int RANDOM_ITEMS    = 1900;
  localparam int POOL_SIZE       = 6;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 400000;
  localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;

  // Receiver stall patterns
  localparam int RX_ALWAYS = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_MOSTLY = 3;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [IN_TDATA_W-1:0]       in_tdata;   // [31:0] value
  logic                        in_tuser;   // [0] kind
  logic                        out_tvalid;
  logic                        out_tready;
  // [1:0] status, [6:2] entry_count, [38:7] largest, [70:39] smallest
  logic [OUT_TDATA_W-1:0]      out_tdata;

  int   error_count;
  int   pending_results;
  int   full_rejects;
  int   empty_rejects;
  int   missing_deletes;
  int   cycle_count = 0;
  int   burst_left  = 0;
  int   inserts_sent = 0;
  int   deletes_sent = 0;
  logic stall_request = 1'b0;
  logic signed [31:0] pool [POOL_SIZE];

  descending_sorted_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  descending_sorted_table_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .error_count     (error_count),
    .pending_results (pending_results),
    .full_rejects    (full_rejects),
    .empty_rejects   (empty_rejects),
    .missing_deletes (missing_deletes)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly the edges of the range and small values, so duplicates occur
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2, 3:    return $urandom;
      default: return $signed($urandom_range(0, 20)) - 10;
    endcase
  endfunction

  // Offer one request at the falling edge and hold it until the transfer
  task automatic send_request(kind_t kind, logic signed [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = stall_request ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = value;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    if (kind == KIND_INSERT) inserts_sent++;
    else deletes_sent++;
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_for_drain();
    in_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Directed: empty delete, extremes, duplicates, absent value, fill to full
  task automatic run_directed();
    send_request(KIND_DELETE, 32'sd5);
    send_request(KIND_INSERT, MAX_VAL);
    send_request(KIND_INSERT, MIN_VAL);
    send_request(KIND_INSERT, 32'sd0);
    send_request(KIND_INSERT, 32'sd0);
    send_request(KIND_INSERT, -32'sd1);
    send_request(KIND_INSERT, 32'sd1);
    send_request(KIND_DELETE, 32'sd42);
    for (int k = 0; k < 10; k++) send_request(KIND_INSERT, 100 * k - 500);
    send_request(KIND_INSERT, 32'sd7);
    send_request(KIND_DELETE, MAX_VAL);
    send_request(KIND_DELETE, MIN_VAL);
    send_request(KIND_DELETE, 32'sd0);
    send_request(KIND_DELETE, 32'sd0);
  endtask

  // Receiver: stall pattern changes every so often; honour a long hold-off
  initial begin
    int mode;
    int tick;
    out_tready = 1'b0;
    mode = RX_ALWAYS;
    tick = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        tick++;
        if (tick % 150 == 0) mode = $urandom_range(RX_ALWAYS, RX_MOSTLY);
        case (mode)
          RX_ALWAYS: out_tready = 1'b1;
          RX_COIN:   out_tready = 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready = (tick % 4 == 0);
          default:   out_tready = ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    int    remaining;
    int    phase;
    int    phase_len;
    int    insert_pct;
    kind_t kind;
    logic signed [31:0] value;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = KIND_INSERT;
    in_tdata  = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    wait_for_drain();

    // Random phases: the insert bias swings so the table fills and empties
    remaining = RANDOM_ITEMS;
    phase = 0;
    while (remaining > 0) begin
      phase_len = $urandom_range(40, 140);
      case ($urandom_range(0, 3))
        0:       insert_pct = 10;
        1:       insert_pct = 50;
        2:       insert_pct = 75;
        default: insert_pct = 95;
      endcase
      foreach (pool[i]) pool[i] = pick_value();
      if (phase == 3) stall_request = 1'b1;
      for (int n = 0; n < phase_len && remaining > 0; n++) begin
        kind  = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
        value = ($urandom_range(0, 4) == 0) ? pick_value()
                                             : pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(kind, value);
        remaining--;
      end
      if (phase == 5 || $urandom_range(0, 3) == 0) wait_for_drain();
      phase++;
    end

    wait_for_drain();
    repeat (10) @(negedge clk);

    $display("Sent %0d inserts and %0d deletes over %0d random phases with varied stalls",
             inserts_sent, deletes_sent, phase);
    $display("Saw %0d full-table rejects, %0d empty-table deletes, %0d absent deletes",
             full_rejects, empty_rejects, missing_deletes);
    if (error_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches counted", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/dst_pkg.sv
src/dst_cell.sv
src/descending_sorted_table.sv
verif/descending_sorted_table_checker.sv
verif/descending_sorted_table_test.sv
